>>> rtl/core/lcdev_pkg.sv
package lcdev_pkg;

	localparam int HW_BITS = 8;
	localparam int SUM_W = 16;
	localparam int CENTER_MAX_W = 11;
	localparam int CNT_MAX_W = 9;
	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_REF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FIRST_ROW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END_ROW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT = 3'd4;

	localparam logic [7:0] CENTER_REF_RST = 8'd98;
	localparam logic [7:0] HALF_WIDTH_RST = 8'd40;
	localparam logic [5:0] WINDOW_FIRST_RST = 6'd0;
	localparam logic [6:0] WINDOW_END_RST = 7'd45;
	localparam logic [7:0] CLAMP_LIMIT_RST = 8'd33;

	typedef struct packed {
		logic [7:0] center_ref;
		logic [7:0] half_width_start;
		logic [5:0] window_first_row;
		logic [6:0] window_end_row;
		logic [7:0] clamp_limit;
	} cfg_t;

	// one row record between front and back
	typedef struct packed {
		logic [CENTER_MAX_W-1:0] center;
		logic invalid;
		logic last;
		logic signed [SUM_W-1:0] sum;
		logic [CNT_MAX_W-1:0] count;
	} row_rec_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_DONE
	} back_state_t;

endpackage

>>> rtl/core/lcdev_front.sv
module lcdev_front import lcdev_pkg::*; #(
	parameter int ROW_COUNT = 64,
	parameter int COL_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [5:0] row_index,
	input logic [COL_BITS-1:0] left_edge,
	input logic [COL_BITS-1:0] right_edge,
	input logic left_lost,
	input logic right_lost,
	input logic row_invalid_in,
	input logic last_row,
	input cfg_t cfg,
	input logic q_full,
	output logic push,
	output row_rec_t rec
);

	localparam int AW = ((COL_BITS > HW_BITS) ? COL_BITS : HW_BITS) + 1;
	localparam int CNT_W = $clog2(ROW_COUNT + 1);

	logic [HW_BITS-1:0] half_width_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;

	logic [AW-1:0] left_x, right_x, hw_x, center, diff;
	logic [HW_BITS-1:0] hw_new;
	logic invalid, hw_upd, in_win, counts;
	logic signed [SUM_W:0] total;
	logic signed [SUM_W-1:0] sum_sat;

	assign left_x = AW'(left_edge);
	assign right_x = AW'(right_edge);
	assign hw_x = AW'(half_width_q);
	assign diff = left_x - right_x;
	assign hw_new = (left_x > right_x) ? diff[HW_BITS:1] : '0;

	always_comb begin
		center = '0;
		invalid = row_invalid_in;
		hw_upd = 1'b0;
		if (!left_lost && right_lost) begin
			if (left_x > hw_x)
				center = left_x - hw_x;
			else
				invalid = 1'b1;
		end else if (left_lost && !right_lost) begin
			if (right_x > hw_x)
				center = right_x + hw_x;
			else
				invalid = 1'b1;
		end else begin
			center = (left_x + right_x) >> 1;
			hw_upd = 1'b1;
		end
	end

	assign in_win = (row_index >= cfg.window_first_row) &&
		({1'b0, row_index} < cfg.window_end_row);
	assign counts = !invalid && !last_row && in_win;

	always_comb begin
		total = {sum_q[SUM_W-1], sum_q} + $signed((SUM_W+1)'(center))
			- $signed((SUM_W+1)'(cfg.center_ref));
		if (total > $signed((SUM_W+1)'(2**(SUM_W-1) - 1)))
			sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
		else if (total < -$signed((SUM_W+1)'(2**(SUM_W-1))))
			sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
		else
			sum_sat = total[SUM_W-1:0];
	end

	assign in_ready = !q_full;
	assign push = in_valid && !q_full;

	always_comb begin
		rec.center = CENTER_MAX_W'(center);
		rec.invalid = invalid;
		rec.last = last_row;
		rec.sum = sum_q;
		rec.count = CNT_MAX_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HALF_WIDTH_RST;
			sum_q <= '0;
			count_q <= '0;
		end else if (push) begin
			if (last_row) begin
				half_width_q <= cfg.half_width_start;
				sum_q <= '0;
				count_q <= '0;
			end else begin
				if (hw_upd)
					half_width_q <= hw_new;
				if (counts) begin
					sum_q <= sum_sat;
					if (count_q < CNT_W'(ROW_COUNT))
						count_q <= count_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/core/lcdev_queue.sv
module lcdev_queue import lcdev_pkg::*; #(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input row_rec_t rec_in,
	output logic full,
	input logic pop,
	output logic head_valid,
	output row_rec_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	row_rec_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign full = (fill_q == CW'(DEPTH));
	assign head_valid = (fill_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= rec_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue pushed while full");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("queue fill count lost a push");

endmodule

>>> rtl/core/lcdev_back.sv
module lcdev_back import lcdev_pkg::*; #(
	parameter int COL_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input row_rec_t head,
	output logic pop,
	input logic [7:0] clamp_limit,
	output logic out_valid,
	input logic out_ready,
	output logic [COL_BITS:0] center_col,
	output logic row_invalid_out,
	output logic signed [8:0] mean_deviation,
	output logic deviation_valid,
	output logic no_valid_rows
);

	back_state_t state_q, state_d;

	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_MAX_W-1:0] rem_q, divisor_q;
	logic neg_q;
	logic [COL_BITS:0] ctr_hold_q;
	logic inv_hold_q;

	logic out_valid_q;
	logic [COL_BITS:0] center_q;
	logic invalid_q, dev_valid_q, none_q;
	logic signed [8:0] mean_q;

	logic can_load, needs_div, load_now, load_div, start_div, div_step;
	logic [CNT_MAX_W:0] trial;
	logic take;
	logic [SUM_W-1:0] sum_abs;
	logic [SUM_W-1:0] mag;
	logic [8:0] mag9;

	assign can_load = !out_valid_q || out_ready;
	assign needs_div = head.last && (head.count != '0);
	assign sum_abs = head.sum[SUM_W-1] ? SUM_W'(-head.sum) : SUM_W'(head.sum);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: if (head_valid && can_load && needs_div) state_d = B_DIV;
			B_DIV: if (step_q == STEP_W'(1)) state_d = B_DONE;
			B_DONE: if (can_load) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		load_now = 1'b0;
		load_div = 1'b0;
		start_div = 1'b0;
		div_step = 1'b0;
		case (state_q)
			B_IDLE: begin
				pop = head_valid && can_load;
				start_div = pop && needs_div;
				load_now = pop && !needs_div;
			end
			B_DIV: div_step = 1'b1;
			B_DONE: load_div = can_load;
			default: ;
		endcase
	end

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign take = trial >= {1'b0, divisor_q};

	assign mag = (quo_q > SUM_W'(clamp_limit)) ? SUM_W'(clamp_limit) : quo_q;
	assign mag9 = mag[8:0];

	always_ff @(posedge clk) begin
		if (start_div) begin
			quo_q <= sum_abs;
			rem_q <= '0;
			divisor_q <= head.count;
			neg_q <= head.sum[SUM_W-1];
			ctr_hold_q <= head.center[COL_BITS:0];
			inv_hold_q <= head.invalid;
		end else if (div_step) begin
			rem_q <= take ? CNT_MAX_W'(trial - {1'b0, divisor_q}) : trial[CNT_MAX_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], take};
		end
		if (load_now) begin
			center_q <= head.center[COL_BITS:0];
			invalid_q <= head.invalid;
			mean_q <= '0;
			dev_valid_q <= head.last;
			none_q <= head.last;
		end else if (load_div) begin
			center_q <= ctr_hold_q;
			invalid_q <= inv_hold_q;
			mean_q <= neg_q ? -$signed(mag9) : $signed(mag9);
			dev_valid_q <= 1'b1;
			none_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_div)
				step_q <= STEP_W'(SUM_W);
			else if (div_step)
				step_q <= step_q - 1'b1;
			if (load_now || load_div)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign center_col = center_q;
	assign row_invalid_out = invalid_q;
	assign mean_deviation = mean_q;
	assign deviation_valid = dev_valid_q;
	assign no_valid_rows = none_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> step_q != '0)
		else $error("divider running with no steps left");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == B_IDLE)
		else $error("row taken while divider busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && none_q) |-> (dev_valid_q && mean_q == '0))
		else $error("empty frame result carries a mean");

endmodule

>>> rtl/core/lane_center_deviation.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | row_index .. last_row
// out     | output    | out_valid / out_ready | center_col .. no_valid_rows
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One row per cycle enters when in_ready; half width, sum and count update as it is taken.
// A row that is not a frame end is registered in the queue, then in the output register.
// A frame end with counted rows goes through the restoring divider (B_DIV, then B_DONE).
// The queue of QUEUE_DEPTH rows lets input keep flowing during a division or an out stall.
// Reset is asynchronous; registers take their listed reset values, queue and output empty.
module lane_center_deviation import lcdev_pkg::*; #(
	parameter int ROW_COUNT = 64,
	parameter int COL_BITS = 8,
	parameter int QUEUE_DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [5:0] row_index,
	input logic [COL_BITS-1:0] left_edge,
	input logic [COL_BITS-1:0] right_edge,
	input logic left_lost,
	input logic right_lost,
	input logic row_invalid_in,
	input logic last_row,
	output logic out_valid,
	input logic out_ready,
	output logic [COL_BITS:0] center_col,
	output logic row_invalid_out,
	output logic signed [8:0] mean_deviation,
	output logic deviation_valid,
	output logic no_valid_rows,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [7:0] cfg_data
);

	cfg_t cfg_q;
	logic q_full, push, pop, head_valid;
	row_rec_t rec, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_ref <= CENTER_REF_RST;
			cfg_q.half_width_start <= HALF_WIDTH_RST;
			cfg_q.window_first_row <= WINDOW_FIRST_RST;
			cfg_q.window_end_row <= WINDOW_END_RST;
			cfg_q.clamp_limit <= CLAMP_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CENTER_REF: cfg_q.center_ref <= cfg_data;
				CFG_HALF_WIDTH_START: cfg_q.half_width_start <= cfg_data;
				CFG_WINDOW_FIRST_ROW: cfg_q.window_first_row <= cfg_data[5:0];
				CFG_WINDOW_END_ROW: cfg_q.window_end_row <= cfg_data[6:0];
				CFG_CLAMP_LIMIT: cfg_q.clamp_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	lcdev_front #(
		.ROW_COUNT(ROW_COUNT),
		.COL_BITS(COL_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.row_index(row_index),
		.left_edge(left_edge),
		.right_edge(right_edge),
		.left_lost(left_lost),
		.right_lost(right_lost),
		.row_invalid_in(row_invalid_in),
		.last_row(last_row),
		.cfg(cfg_q),
		.q_full(q_full),
		.push(push),
		.rec(rec)
	);

	lcdev_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.rec_in(rec),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head(head)
	);

	lcdev_back #(
		.COL_BITS(COL_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.clamp_limit(cfg_q.clamp_limit),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.center_col(center_col),
		.row_invalid_out(row_invalid_out),
		.mean_deviation(mean_deviation),
		.deviation_valid(deviation_valid),
		.no_valid_rows(no_valid_rows)
	);

endmodule

>>> dv/tb_lane_center_deviation.sv
`timescale 1ns / 100ps

module tb_lane_center_deviation import lcdev_pkg::*;;

	localparam int ROW_LIMIT = 64;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [5:0] row;
		logic [7:0] left;
		logic [7:0] right;
		logic l_lost;
		logic r_lost;
		logic inv;
		logic last_flag;
	} lane_row_t;

	typedef struct packed {
		logic [8:0] center;
		logic inv;
		logic signed [8:0] mean;
		logic dev_valid;
		logic no_rows;
	} lane_res_t;

	typedef enum int {
		ROW_RANDOM,
		ROW_WIDE,
		ROW_HIGH,
		ROW_LOW
	} row_kind_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [5:0] row_index = '0;
	logic [7:0] left_edge = '0;
	logic [7:0] right_edge = '0;
	logic left_lost = 1'b0;
	logic right_lost = 1'b0;
	logic row_invalid_in = 1'b0;
	logic last_row = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [8:0] center_col;
	logic row_invalid_out;
	logic signed [8:0] mean_deviation;
	logic deviation_valid;
	logic no_valid_rows;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CENTER_REF;
	logic [7:0] cfg_data = '0;

	lane_center_deviation uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.row_index(row_index),
		.left_edge(left_edge),
		.right_edge(right_edge),
		.left_lost(left_lost),
		.right_lost(right_lost),
		.row_invalid_in(row_invalid_in),
		.last_row(last_row),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.center_col(center_col),
		.row_invalid_out(row_invalid_out),
		.mean_deviation(mean_deviation),
		.deviation_valid(deviation_valid),
		.no_valid_rows(no_valid_rows),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// lane model state
	cfg_t lane_cfg;
	logic [7:0] half_w;
	int dev_sum;
	int dev_count;

	lane_row_t pending_rows[$];
	lane_res_t expected_rows[$];
	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic in_taken = 1'b0;
	logic [5:0] row_ctr = '0;
	lane_row_t drive_row;

	function automatic void start_frame();
		half_w = lane_cfg.half_width_start;
		dev_sum = 0;
		dev_count = 0;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		case (idx)
			CFG_CENTER_REF: lane_cfg.center_ref = val;
			CFG_HALF_WIDTH_START: lane_cfg.half_width_start = val;
			CFG_WINDOW_FIRST_ROW: lane_cfg.window_first_row = val[5:0];
			CFG_WINDOW_END_ROW: lane_cfg.window_end_row = val[6:0];
			CFG_CLAMP_LIMIT: lane_cfg.clamp_limit = val;
			default: ;
		endcase
	endfunction

	function automatic lane_res_t predict_row(lane_row_t r);
		lane_res_t res;
		logic bad;
		int s;
		int lim;
		int m;
		res = '0;
		bad = r.inv;
		if (!r.l_lost && r.r_lost) begin
			if (r.left > half_w)
				res.center = {1'b0, r.left} - {1'b0, half_w};
			else
				bad = 1'b1;
		end else if (r.l_lost && !r.r_lost) begin
			if (r.right > half_w)
				res.center = {1'b0, r.right} + {1'b0, half_w};
			else
				bad = 1'b1;
		end else begin
			res.center = ({1'b0, r.left} + {1'b0, r.right}) >> 1;
			half_w = (r.left > r.right) ? 8'((r.left - r.right) >> 1) : 8'd0;
		end
		if (!bad && !r.last_flag && int'(r.row) >= int'(lane_cfg.window_first_row)
				&& int'(r.row) < int'(lane_cfg.window_end_row)) begin
			s = dev_sum + int'(res.center) - int'(lane_cfg.center_ref);
			if (s > 32767)
				s = 32767;
			if (s < -32768)
				s = -32768;
			dev_sum = s;
			if (dev_count < ROW_LIMIT)
				dev_count++;
		end
		if (r.last_flag) begin
			res.dev_valid = 1'b1;
			if (dev_count == 0) begin
				res.no_rows = 1'b1;
			end else begin
				lim = int'(lane_cfg.clamp_limit);
				m = dev_sum / dev_count;
				if (m > lim)
					m = lim;
				if (m < -lim)
					m = -lim;
				res.mean = 9'(m);
			end
			start_frame();
		end
		res.inv = bad;
		return res;
	endfunction

	function automatic lane_row_t mk(logic [5:0] row, logic [7:0] left, logic [7:0] right,
			logic ll, logic rl, logic inv, logic lastf);
		lane_row_t r;
		r.row = row;
		r.left = left;
		r.right = right;
		r.l_lost = ll;
		r.r_lost = rl;
		r.inv = inv;
		r.last_flag = lastf;
		return r;
	endfunction

	function automatic lane_row_t make_row(row_kind_e kind, logic [5:0] row, logic lastf);
		lane_row_t r;
		int sel;
		logic [7:0] tmp;
		sel = $urandom_range(0, 15);
		case (kind)
			ROW_WIDE: r = mk(row, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0, lastf);
			ROW_HIGH: r = mk(row, 8'($urandom), 8'd255, 1'b1, 1'b0, 1'b0, lastf);
			ROW_LOW: r = mk(row, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, lastf);
			default: begin
				r.row = row;
				r.last_flag = lastf;
				r.inv = ($urandom_range(0, 7) == 0);
				r.right = 8'($urandom_range(0, 200));
				r.left = 8'(int'(r.right) + $urandom_range(0, 255 - int'(r.right)));
				r.l_lost = 1'b0;
				r.r_lost = 1'b0;
				if (sel == 9) begin
					tmp = r.left;
					r.left = r.right;
					r.right = tmp;
				end else if (sel == 10 || sel == 11) begin
					r.r_lost = 1'b1;
				end else if (sel == 12 || sel == 13) begin
					r.l_lost = 1'b1;
				end else if (sel == 14) begin
					r.l_lost = 1'b1;
					r.r_lost = 1'b1;
				end else if (sel == 15) begin
					r = lane_row_t'({$urandom, $urandom});
					r.row = row;
					r.last_flag = lastf;
				end
			end
		endcase
		return r;
	endfunction

	task automatic queue_rows(row_kind_e kind, int n);
		for (int i = 0; i < n; i++) begin
			pending_rows.push_back(make_row(kind, row_ctr, 1'b0));
			row_ctr++;
		end
	endtask

	task automatic queue_random_frames(int target);
		int total;
		int len;
		int pick;
		logic [5:0] row;
		total = 0;
		while (total < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				len = $urandom_range(1, 24);
			else if (pick < 95)
				len = $urandom_range(25, 70);
			else
				len = $urandom_range(71, 130);
			row_ctr = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd0;
			for (int i = 0; i < len; i++) begin
				row = ($urandom_range(0, 9) == 0) ? 6'($urandom) : row_ctr;
				pending_rows.push_back(make_row(ROW_RANDOM, row, i == len - 1));
				row_ctr++;
			end
			total += len;
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(logic [7:0] cref, logic [7:0] hws, logic [5:0] first_row,
			logic [6:0] end_row, logic [7:0] clamp);
		write_reg(CFG_CENTER_REF, cref);
		write_reg(CFG_HALF_WIDTH_START, hws);
		write_reg(CFG_WINDOW_FIRST_ROW, {2'b00, first_row});
		write_reg(CFG_WINDOW_END_ROW, {1'b0, end_row});
		write_reg(CFG_CLAMP_LIMIT, clamp);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(int mode);
		send_idle_pct = (mode == 1) ? 48 : (mode == 3) ? 14 : 0;
		recv_stall_pct = (mode == 2) ? 48 : (mode == 3) ? 14 : 0;
	endtask

	task automatic wait_drained();
		while (pending_rows.size() != 0 || in_valid || expected_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// driver: payload and handshakes change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			if (!in_valid || in_taken) begin
				if (pending_rows.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					drive_row = pending_rows.pop_front();
					row_index <= drive_row.row;
					left_edge <= drive_row.left;
					right_edge <= drive_row.right;
					left_lost <= drive_row.l_lost;
					right_lost <= drive_row.r_lost;
					row_invalid_in <= drive_row.inv;
					last_row <= drive_row.last_flag;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: handshakes sampled on the rising edge
	always @(posedge clk) begin
		lane_res_t exp_res;
		in_taken = in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (in_taken)
				expected_rows.push_back(predict_row(mk(row_index, left_edge, right_edge,
					left_lost, right_lost, row_invalid_in, last_row)));
			if (out_valid && out_ready) begin
				if (expected_rows.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("ERROR: unexpected item center=%0d inv=%0b mean=%0d dv=%0b nv=%0b",
							center_col, row_invalid_out, mean_deviation, deviation_valid,
							no_valid_rows);
				end else begin
					exp_res = expected_rows.pop_front();
					if (center_col !== exp_res.center || row_invalid_out !== exp_res.inv
							|| mean_deviation !== exp_res.mean
							|| deviation_valid !== exp_res.dev_valid
							|| no_valid_rows !== exp_res.no_rows) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display({"ERROR: center %0d/%0d inv %0b/%0b mean %0d/%0d",
								" dv %0b/%0b nv %0b/%0b (expected/actual)"},
								exp_res.center, center_col, exp_res.inv, row_invalid_out,
								exp_res.mean, mean_deviation, exp_res.dev_valid,
								deviation_valid, exp_res.no_rows, no_valid_rows);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("lane_center_deviation regression: fail");
			$finish;
		end
	end

	initial begin
		lane_cfg.center_ref = CENTER_REF_RST;
		lane_cfg.half_width_start = HALF_WIDTH_RST;
		lane_cfg.window_first_row = WINDOW_FIRST_RST;
		lane_cfg.window_end_row = WINDOW_END_RST;
		lane_cfg.clamp_limit = CLAMP_LIMIT_RST;
		start_frame();
		set_idling(0);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset settings: empty frame, edge fills, window bounds, clamping
		pending_rows.push_back(mk(6'd0, 8'd120, 8'd60, 1'b0, 1'b0, 1'b0, 1'b1));
		pending_rows.push_back(mk(6'd0, 8'd100, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd1, 8'd40, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd2, 8'd0, 8'd41, 1'b1, 1'b0, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd3, 8'd0, 8'd40, 1'b1, 1'b0, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd4, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd5, 8'd0, 8'd255, 1'b1, 1'b1, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd6, 8'd1, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd7, 8'd200, 8'd100, 1'b0, 1'b0, 1'b1, 1'b0));
		pending_rows.push_back(mk(6'd44, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd45, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd63, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd10, 8'd180, 8'd20, 1'b0, 1'b0, 1'b0, 1'b1));
		pending_rows.push_back(mk(6'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd1, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd2, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd3, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1));
		pending_rows.push_back(mk(6'd0, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd1, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0));
		pending_rows.push_back(mk(6'd2, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0, 1'b1));
		pending_rows.push_back(mk(6'd5, 8'd90, 8'd10, 1'b0, 1'b0, 1'b1, 1'b0));
		pending_rows.push_back(mk(6'd6, 8'd90, 8'd10, 1'b0, 1'b0, 1'b1, 1'b1));
		wait_drained();

		for (int ph = 1; ph <= 7; ph++) begin
			case (ph)
				1: program_regs(8'd128, 8'd0, 6'd0, 7'd64, 8'd255);
				2: program_regs(8'd255, 8'd255, 6'd0, 7'd64, 8'd255);
				3: program_regs(8'd0, 8'd128, 6'd63, 7'd64, 8'd0);
				4: program_regs(8'd98, 8'd40, 6'd40, 7'd20, 8'd33);
				5: program_regs(8'd100, 8'd60, 6'd0, 7'd0, 8'd20);
				default: program_regs(8'($urandom_range(40, 200)), 8'($urandom),
					6'($urandom_range(0, 30)), 7'($urandom_range(20, 64)), 8'($urandom));
			endcase
			set_idling(ph % 4);
			if (ph == 1) begin
				// sum hits the positive rail, then falls back
				row_ctr = '0;
				queue_rows(ROW_WIDE, 1);
				queue_rows(ROW_HIGH, 139);
				queue_rows(ROW_LOW, 30);
				pending_rows.push_back(make_row(ROW_LOW, row_ctr, 1'b1));
			end else if (ph == 2) begin
				// sum hits the negative rail, then climbs back
				row_ctr = '0;
				queue_rows(ROW_LOW, 130);
				queue_rows(ROW_WIDE, 1);
				queue_rows(ROW_HIGH, 30);
				pending_rows.push_back(make_row(ROW_HIGH, row_ctr, 1'b1));
			end
			queue_random_frames((ph <= 2) ? 10 : 25);
			wait_drained();
		end

		if (mismatch_cnt == 0 && expected_rows.size() == 0)
			$display("lane_center_deviation regression: pass");
		else
			$display("lane_center_deviation regression: fail");
		$finish;
	end

endmodule
